### design/upsf_pkg.sv
// ----------------------------------------------------------------------------
// upsf_pkg: shared types and constants of the URL path safety filter
// Payload structs of both channels, the entry that the front hands to the
// back through the queue, verdict reason codes and defaults.
// ----------------------------------------------------------------------------
package upsf_pkg;

	localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;
	localparam logic [7:0]  MAX_LENGTH_RESET    = 8'd40;

	// verdict reason codes
	localparam logic [2:0] RSN_OK     = 3'd0;
	localparam logic [2:0] RSN_LENGTH = 3'd1;
	localparam logic [2:0] RSN_ROOT   = 3'd2;
	localparam logic [2:0] RSN_CTRL   = 3'd3;
	localparam logic [2:0] RSN_DOT    = 3'd4;
	localparam logic [2:0] RSN_DOUBLE = 3'd5;
	localparam logic [2:0] RSN_BADCHR = 3'd6;
	localparam logic [2:0] RSN_SQL    = 3'd7;

	typedef struct packed {
		logic [7:0] path_byte;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic       accepted;
		logic [2:0] reason;
	} out_item_t;

	// percent escape decoder state
	typedef enum logic [1:0] {
		ESC_NONE,
		ESC_PCT,
		ESC_HEX1
	} esc_state_t;

	// one raw byte worth of decoded output, plus raw-side verdict bits
	typedef struct packed {
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic [1:0] num;
		logic       last;
		logic       len_fail;
		logic       dbl_fail;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// per-path state of the decoded-byte checker
	typedef struct packed {
		logic [39:0] window;
		logic [2:0]  count;
		logic        root_fail;
		logic        ctrl_fail;
		logic        dot_fail;
		logic        bad_fail;
		logic        sql_fail;
	} back_state_t;

endpackage

### design/upsf_front.sv
// ----------------------------------------------------------------------------
// upsf_front: raw byte stage
// Counts raw bytes, spots doubled slashes, decodes percent escapes and
// builds one queue entry per accepted byte.
// ----------------------------------------------------------------------------
module upsf_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           max_length,
	input  logic                 accept,
	input  upsf_pkg::in_item_t   item,
	output upsf_pkg::q_entry_t   entry
);

	upsf_pkg::esc_state_t esc_q, esc_d;
	logic [7:0] cnt_q, cnt_d;
	logic       ovf_q, ovf_d;
	logic [7:0] prev_q;
	logic       dbl_q, dbl_d;
	logic [7:0] first_q;
	logic [7:0] b;

	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'h00;
		if (c >= "0" && c <= "9") r = {1'b1, 4'(c - "0")};
		else if (c >= "a" && c <= "f") r = {1'b1, 4'(c - "a" + 8'd10)};
		else if (c >= "A" && c <= "F") r = {1'b1, 4'(c - "A" + 8'd10)};
		return r;
	endfunction

	// strtol base 16 on a two-byte string, modulo 256
	function automatic logic [7:0] decode_pair(input logic [7:0] a, input logic [7:0] c);
		logic [4:0] da;
		logic [4:0] dc;
		logic [7:0] r;
		da = hex_digit(a);
		dc = hex_digit(c);
		if (da[4]) begin
			r = dc[4] ? {da[3:0], dc[3:0]} : {4'h0, da[3:0]};
		end else if (a == " " || (a >= 8'h09 && a <= 8'h0D) || a == "+") begin
			r = dc[4] ? {4'h0, dc[3:0]} : 8'h00;
		end else if (a == "-") begin
			r = dc[4] ? 8'(8'h00 - {4'h0, dc[3:0]}) : 8'h00;
		end else begin
			r = 8'h00;
		end
		return r;
	endfunction

	assign b = item.path_byte;

	always_comb begin
		cnt_d = (cnt_q == 8'hFF) ? cnt_q : cnt_q + 8'd1;
		ovf_d = ovf_q | (cnt_q == 8'hFF);
		dbl_d = dbl_q | ((cnt_q != 8'd0) &&
			((b == "/" && prev_q == "/") || (b == "\\" && prev_q == "\\")));

		esc_d          = esc_q;
		entry.byte0    = b;
		entry.byte1    = b;
		entry.num      = 2'd0;
		entry.last     = item.last;
		entry.len_fail = ovf_d || (cnt_d > max_length);
		entry.dbl_fail = dbl_d;

		case (esc_q)
			upsf_pkg::ESC_PCT: begin
				if (item.last) begin
					// escape cut short: the percent and this byte stay literal
					entry.byte0 = "%";
					entry.num   = 2'd2;
					esc_d       = upsf_pkg::ESC_NONE;
				end else begin
					esc_d = upsf_pkg::ESC_HEX1;
				end
			end
			upsf_pkg::ESC_HEX1: begin
				entry.byte0 = decode_pair(first_q, b);
				entry.num   = 2'd1;
				esc_d       = upsf_pkg::ESC_NONE;
			end
			default: begin
				if (b == "%" && !item.last) begin
					esc_d = upsf_pkg::ESC_PCT;
				end else begin
					entry.num = 2'd1;
					esc_d     = upsf_pkg::ESC_NONE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q  <= upsf_pkg::ESC_NONE;
			cnt_q  <= 8'd0;
			ovf_q  <= 1'b0;
			prev_q <= 8'd0;
			dbl_q  <= 1'b0;
		end else if (accept) begin
			if (item.last) begin
				esc_q  <= upsf_pkg::ESC_NONE;
				cnt_q  <= 8'd0;
				ovf_q  <= 1'b0;
				prev_q <= 8'd0;
				dbl_q  <= 1'b0;
			end else begin
				esc_q  <= esc_d;
				cnt_q  <= cnt_d;
				ovf_q  <= ovf_d;
				prev_q <= b;
				dbl_q  <= dbl_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && esc_q == upsf_pkg::ESC_PCT && !item.last) begin
			first_q <= b;
		end
	end

endmodule

### design/upsf_queue.sv
// ----------------------------------------------------------------------------
// upsf_queue: entry queue between front and back
// Small register FIFO; the head is visible combinationally.
// ----------------------------------------------------------------------------
module upsf_queue #(
	parameter int unsigned DEPTH = upsf_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  upsf_pkg::q_entry_t  wr_entry,
	input  logic                pop,
	output upsf_pkg::q_entry_t  head,
	output upsf_pkg::q_status_t status
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	upsf_pkg::q_entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign head         = mem_q[rd_ptr_q];
	assign status.full  = (cnt_q == CNT_FULL);
	assign status.empty = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)  rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !pop)      cnt_q <= cnt_q + CNT_W'(1);
			else if (pop && !push) cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_entry;
	end

endmodule

### design/upsf_back.sv
// ----------------------------------------------------------------------------
// upsf_back: decoded byte checker and verdict register
// Runs the decoded-byte checks on each entry and holds the verdict until
// the receiver takes it.
// ----------------------------------------------------------------------------
module upsf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  upsf_pkg::q_entry_t  head,
	input  logic                head_valid,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output upsf_pkg::out_item_t out_data
);

	upsf_pkg::back_state_t state_q, s1, s2;
	upsf_pkg::out_item_t   verdict;
	logic                  out_valid_q;
	upsf_pkg::out_item_t   out_data_q;

	function automatic upsf_pkg::back_state_t take_byte(
		input upsf_pkg::back_state_t s,
		input logic [7:0]            c
	);
		upsf_pkg::back_state_t r;
		logic [7:0] w0, w1, w2, w3, w4;
		logic       ok_chr;
		logic       sql;
		r  = s;
		w0 = s.window[7:0];
		w1 = s.window[15:8];
		w2 = s.window[23:16];
		w3 = s.window[31:24];
		w4 = s.window[39:32];
		ok_chr = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
			(c >= "0" && c <= "9") || c == "/" || c == "_" || c == "-" || c == ".";
		sql = (c == "-" && s.count >= 3'd1 && w0 == "-") ||
			(c == "*" && s.count >= 3'd1 && w0 == "/") ||
			(c == "/" && s.count >= 3'd1 && w0 == "*") ||
			(c == "_" && s.count >= 3'd2 && w0 == "p" && w1 == "x") ||
			(c == "c" && s.count >= 3'd3 && w0 == "e" && w1 == "x" && w2 == "e") ||
			(c == "n" && s.count >= 3'd4 && w0 == "o" && w1 == "i" && w2 == "n" &&
				w3 == "u") ||
			(c == "t" && s.count >= 3'd5 && w0 == "c" && w1 == "e" && w2 == "l" &&
				w3 == "e" && w4 == "s");
		r.root_fail = s.root_fail | (s.count == 3'd0 && c != "/");
		r.ctrl_fail = s.ctrl_fail | (c < 8'h20);
		r.dot_fail  = s.dot_fail | (c == "~" || c == "\\" || c == "%" ||
			(c == "." && s.count >= 3'd1 && w0 == "."));
		r.bad_fail  = s.bad_fail | !ok_chr;
		r.sql_fail  = s.sql_fail | sql;
		r.window    = {s.window[31:0], c};
		r.count     = (s.count == 3'd7) ? s.count : s.count + 3'd1;
		return r;
	endfunction

	// a closing entry waits until the verdict register is free
	assign pop = head_valid && (!head.last || !out_valid_q || !out_stall);

	always_comb begin
		s1 = (head.num != 2'd0) ? take_byte(state_q, head.byte0) : state_q;
		s2 = (head.num == 2'd2) ? take_byte(s1, head.byte1) : s1;

		if (head.len_fail)  verdict.reason = upsf_pkg::RSN_LENGTH;
		else if (s2.root_fail) verdict.reason = upsf_pkg::RSN_ROOT;
		else if (s2.ctrl_fail) verdict.reason = upsf_pkg::RSN_CTRL;
		else if (s2.dot_fail)  verdict.reason = upsf_pkg::RSN_DOT;
		else if (head.dbl_fail) verdict.reason = upsf_pkg::RSN_DOUBLE;
		else if (s2.bad_fail)  verdict.reason = upsf_pkg::RSN_BADCHR;
		else if (s2.sql_fail)  verdict.reason = upsf_pkg::RSN_SQL;
		else verdict.reason = upsf_pkg::RSN_OK;
		verdict.accepted = (verdict.reason == upsf_pkg::RSN_OK);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				state_q <= head.last ? '0 : s2;
			end
			if (pop && head.last) out_valid_q <= 1'b1;
			else if (!out_stall)  out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.last) out_data_q <= verdict;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

### design/url_path_safety_filter.sv
// ----------------------------------------------------------------------------
// url_path_safety_filter: streaming URL path checker
// Takes raw path bytes one per transfer and gives one pass/fail verdict with
// a reason code after the byte marked last.
// ----------------------------------------------------------------------------
// Usage:
//   in channel : in_valid / in_stall, payload in_data (path_byte, last).
//   out channel: out_valid / out_stall, payload out_data (accepted, reason).
//   config     : cfg_we / cfg_wdata writes max_length; write only while idle.
// Throughput: one byte per cycle while in_stall is low, paths back to back
//   with no gap. The front stage handles each raw byte as it is taken, the
//   back stage checks up to two decoded bytes of one entry per cycle unless
//   a closing entry waits for the verdict register. Output: the last byte is
//   written into the queue, the back stage pops its closing entry and the
//   verdict register raises out_valid, when the queue is empty and the output is free.
// Stall: a held verdict stops the back stage only at the next closing entry;
//   the queue then fills and in_stall rises when it is full.
// Reset: arst_n clears all path state, empties the queue, drops any pending
//   verdict and sets max_length to 40. No clearing pass is needed.
// ----------------------------------------------------------------------------
module url_path_safety_filter #(
	parameter int unsigned QUEUE_DEPTH = upsf_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  upsf_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output upsf_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic [7:0]          cfg_wdata
);

	logic                max_length_q;
	logic [7:0]          max_len_q;
	logic                push;
	logic                pop;
	upsf_pkg::q_entry_t  wr_entry;
	upsf_pkg::q_entry_t  head;
	upsf_pkg::q_status_t q_status;

	// hold the limit register; the user must write it only between paths, the block itself does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q    <= upsf_pkg::MAX_LENGTH_RESET;
			max_length_q <= 1'b0;
		end else begin
			max_length_q <= cfg_we;
			if (cfg_we) max_len_q <= cfg_wdata;
		end
	end

	// take a byte whenever the queue has room
	assign in_stall = q_status.full;
	assign push     = in_valid && !in_stall;

	upsf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.max_length (max_len_q),
		.accept     (push),
		.item       (in_data),
		.entry      (wr_entry)
	);

	upsf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.head     (head),
		.status   (q_status)
	);

	upsf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (!q_status.empty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

	// verdict flag agrees with its reason code
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.accepted == (out_data.reason == upsf_pkg::RSN_OK)))
	else $error("accepted flag disagrees with reason");

	// a closing entry never overwrites a verdict still held by the receiver
	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.last) |-> !(out_valid && out_stall))
	else $error("verdict overwritten while stalled");

	// a new verdict only follows the pop of a closing entry
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(pop && head.last))
	else $error("verdict without closing entry");

	// the back stage pops only while the queue holds an entry
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
	else $error("pop from empty queue");

	// limit register tracks the last write
	assert property (@(posedge clk) disable iff (!arst_n)
		max_length_q |-> (max_len_q == $past(cfg_wdata)))
	else $error("max_length not written");

endmodule
